/* design/nsgc_pkg.sv */
`default_nettype none
package nsgc_pkg;

	// source frame geometry
	localparam int unsigned SRC_WIDTH   = 320;
	localparam int unsigned SRC_HEIGHT  = 240;
	localparam int unsigned SRC_PIXELS  = SRC_WIDTH * SRC_HEIGHT;
	localparam int unsigned MAX_OUT_DIM = 1024;

	localparam int unsigned ADDR_W = $clog2(SRC_PIXELS);
	localparam int unsigned PIX_W  = 24;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DIM_W  = 11;
	localparam int unsigned POS_W  = 10;

	// restoring divider: one quotient bit per stage
	localparam int unsigned QUOT_W     = 9;
	localparam int unsigned REM_W      = 20;
	localparam int unsigned DIV_STAGES = QUOT_W;

	// gray weights, sum of weights is the divisor
	localparam int unsigned W_B0        = 820;
	localparam int unsigned W_B1        = 6094;
	localparam int unsigned W_B2        = 3086;
	localparam int unsigned SUM_W       = 22;
	// floor(x / 10000) == (x * RECIP_M) >> RECIP_SHIFT for x < 2**SUM_W
	localparam int unsigned RECIP_M     = 27487791;
	localparam int unsigned RECIP_W     = 25;
	localparam int unsigned RECIP_SHIFT = 38;
	localparam int unsigned PROD_W      = SUM_W + RECIP_W;

	// result queue
	localparam int unsigned FIFO_DEPTH = 32;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = FIFO_AW + 1;

	// item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_FETCH = 1'b1;

	// register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RGB_MODE   = 2'd2;

	localparam logic [DIM_W-1:0] RST_OUT_WIDTH  = DIM_W'(SRC_WIDTH);
	localparam logic [DIM_W-1:0] RST_OUT_HEIGHT = DIM_W'(SRC_HEIGHT);

	typedef struct packed {
		logic               valid;
		logic               fetch;
		logic               oor;
		logic [ADDR_W-1:0]  addr;
		logic [PIX_W-1:0]   pixel;
		logic [REM_W-1:0]   rem_r;
		logic [REM_W-1:0]   rem_c;
		logic [QUOT_W-1:0]  q_r;
		logic [QUOT_W-1:0]  q_c;
	} div_item_t;

	typedef struct packed {
		logic valid;
		logic oor;
	} meta_t;

	typedef struct packed {
		logic [BYTE_W-1:0] gray;
		logic              oor;
	} res_t;

endpackage
`default_nettype wire

/* design/nsgc_ram.sv */
`default_nettype none
module nsgc_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

/* design/nsgc_scale_div.sv */
`default_nettype none
// Two restoring dividers side by side, one quotient bit per stage, MSB first.
// Loads ride along untouched so that store accesses keep item order.
module nsgc_scale_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire nsgc_pkg::div_item_t            in_item,
	input  wire logic [nsgc_pkg::DIM_W-1:0]     out_width,
	input  wire logic [nsgc_pkg::DIM_W-1:0]     out_height,
	output nsgc_pkg::div_item_t                 out_item
);

	nsgc_pkg::div_item_t pipe [nsgc_pkg::DIV_STAGES+1];

	assign pipe[0]  = in_item;
	assign out_item = pipe[nsgc_pkg::DIV_STAGES];

	for (genvar k = 0; k < nsgc_pkg::DIV_STAGES; k++) begin : g_stage
		localparam int unsigned B = nsgc_pkg::QUOT_W - 1 - k;

		nsgc_pkg::div_item_t         nxt;
		logic [nsgc_pkg::REM_W-1:0]  dsh_r;
		logic [nsgc_pkg::REM_W-1:0]  dsh_c;

		assign dsh_r = nsgc_pkg::REM_W'(out_height) << B;
		assign dsh_c = nsgc_pkg::REM_W'(out_width) << B;

		always_comb begin
			nxt = pipe[k];
			if (pipe[k].rem_r >= dsh_r) begin
				nxt.rem_r  = pipe[k].rem_r - dsh_r;
				nxt.q_r[B] = 1'b1;
			end
			if (pipe[k].rem_c >= dsh_c) begin
				nxt.rem_c  = pipe[k].rem_c - dsh_c;
				nxt.q_c[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pipe[k+1] <= '0;
			end else begin
				pipe[k+1] <= nxt;
			end
		end
	end

endmodule
`default_nettype wire

/* design/nsgc_out_fifo.sv */
`default_nettype none
// Result queue; the top level reserves a slot per fetch, so push never overflows.
module nsgc_out_fifo (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire nsgc_pkg::res_t       push_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output nsgc_pkg::res_t            out_data
);

	nsgc_pkg::res_t                  entries_q [nsgc_pkg::FIFO_DEPTH];
	logic [nsgc_pkg::FIFO_AW-1:0]    wr_ptr_q;
	logic [nsgc_pkg::FIFO_AW-1:0]    rd_ptr_q;
	logic [nsgc_pkg::CNT_W-1:0]      count_q;
	logic                            pop;

	assign out_valid = (count_q != '0);
	assign out_data  = entries_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/nearest_scale_gray_convert_core.sv */
`default_nettype none
// Channel   Handshake          Payload
// in        in_valid/in_stall  mode, src_addr, byte_first..third, out_col, out_row
// out       out_valid/out_stall gray, out_of_range
// cfg       cfg_we             cfg_index, cfg_wdata (no stall, no read-back)
//
// One item per clock while in_stall is low. A fetch result passes the input
// register, nine divider stages, the pixel RAM read, the weighted sum, the queue.
// Loads and fetches share the single RAM port at one fixed stage, so no hazard.
// in_stall rises only when all 32 queue slots are reserved by pending fetches.
// Reset: 320x240 output, luma mode, queue empty; the pixel store is not cleared.
module nearest_scale_gray_convert_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                mode,
	input  wire logic [nsgc_pkg::ADDR_W-1:0]         src_addr,
	input  wire logic [nsgc_pkg::BYTE_W-1:0]         byte_first,
	input  wire logic [nsgc_pkg::BYTE_W-1:0]         byte_second,
	input  wire logic [nsgc_pkg::BYTE_W-1:0]         byte_third,
	input  wire logic [nsgc_pkg::POS_W-1:0]          out_col,
	input  wire logic [nsgc_pkg::POS_W-1:0]          out_row,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [nsgc_pkg::BYTE_W-1:0]              gray,
	output logic                                     out_of_range,
	input  wire logic                                cfg_we,
	input  wire logic [nsgc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [nsgc_pkg::DIM_W-1:0]          cfg_wdata
);

	logic [nsgc_pkg::DIM_W-1:0]   out_width_q;
	logic [nsgc_pkg::DIM_W-1:0]   out_height_q;
	logic                         rgb_mode_q;
	logic [nsgc_pkg::DIM_W-1:0]   dim_clamped;

	logic [nsgc_pkg::CNT_W-1:0]   occ_q;
	logic                         in_acc;
	logic                         in_oor;
	logic                         pop;

	nsgc_pkg::div_item_t          ent_s1;
	nsgc_pkg::div_item_t          div_out;

	logic [nsgc_pkg::ADDR_W-1:0]  ram_addr;
	logic                         ram_we;
	logic [nsgc_pkg::PIX_W-1:0]   ram_rdata;

	nsgc_pkg::meta_t              meta_s11;
	nsgc_pkg::meta_t              meta_s12;
	logic [nsgc_pkg::SUM_W-1:0]   sum_s12;
	logic [nsgc_pkg::BYTE_W-1:0]  luma_s12;
	logic [nsgc_pkg::PROD_W-1:0]  product;
	nsgc_pkg::res_t               push_data;
	nsgc_pkg::res_t               out_data;

	// ---------------- configuration ----------------
	assign dim_clamped = (cfg_wdata > nsgc_pkg::DIM_W'(nsgc_pkg::MAX_OUT_DIM))
		? nsgc_pkg::DIM_W'(nsgc_pkg::MAX_OUT_DIM) : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_width_q  <= nsgc_pkg::RST_OUT_WIDTH;
			out_height_q <= nsgc_pkg::RST_OUT_HEIGHT;
			rgb_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nsgc_pkg::REG_OUT_WIDTH:  out_width_q  <= dim_clamped;
				nsgc_pkg::REG_OUT_HEIGHT: out_height_q <= dim_clamped;
				nsgc_pkg::REG_RGB_MODE:   rgb_mode_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// ---------------- input and slot reservation ----------------
	assign in_stall = (occ_q == nsgc_pkg::CNT_W'(nsgc_pkg::FIFO_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;
	assign in_oor   = ({1'b0, out_col} >= out_width_q) || ({1'b0, out_row} >= out_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({in_acc && (mode == nsgc_pkg::MODE_FETCH), pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_s1 <= '0;
		end else begin
			ent_s1.valid <= in_acc;
			ent_s1.fetch <= (mode == nsgc_pkg::MODE_FETCH);
			ent_s1.oor   <= in_oor;
			ent_s1.addr  <= src_addr;
			ent_s1.pixel <= {byte_third, byte_second, byte_first};
			ent_s1.rem_r <= nsgc_pkg::REM_W'(out_row) * nsgc_pkg::REM_W'(nsgc_pkg::SRC_HEIGHT);
			ent_s1.rem_c <= nsgc_pkg::REM_W'(out_col) * nsgc_pkg::REM_W'(nsgc_pkg::SRC_WIDTH);
			ent_s1.q_r   <= '0;
			ent_s1.q_c   <= '0;
		end
	end

	// ---------------- source position ----------------
	nsgc_scale_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (ent_s1),
		.out_width  (out_width_q),
		.out_height (out_height_q),
		.out_item   (div_out)
	);

	// ---------------- pixel store access ----------------
	always_comb begin
		if (div_out.fetch) begin
			ram_addr = nsgc_pkg::ADDR_W'(div_out.q_r)
				* nsgc_pkg::ADDR_W'(nsgc_pkg::SRC_WIDTH)
				+ nsgc_pkg::ADDR_W'(div_out.q_c);
		end else begin
			ram_addr = div_out.addr;
		end
	end

	// out-of-frame loads are dropped
	assign ram_we = div_out.valid && !div_out.fetch
		&& (div_out.addr < nsgc_pkg::ADDR_W'(nsgc_pkg::SRC_PIXELS));

	nsgc_ram #(
		.WIDTH (nsgc_pkg::PIX_W),
		.DEPTH (nsgc_pkg::SRC_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (div_out.pixel),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s11 <= '0;
			meta_s12 <= '0;
		end else begin
			meta_s11.valid <= div_out.valid && div_out.fetch;
			meta_s11.oor   <= div_out.oor;
			meta_s12       <= meta_s11;
		end
	end

	// ---------------- gray conversion ----------------
	always_ff @(posedge clk) begin
		luma_s12 <= ram_rdata[nsgc_pkg::BYTE_W-1:0];
		sum_s12  <= nsgc_pkg::SUM_W'(nsgc_pkg::W_B0)
				* nsgc_pkg::SUM_W'(ram_rdata[nsgc_pkg::BYTE_W-1:0])
			+ nsgc_pkg::SUM_W'(nsgc_pkg::W_B1)
				* nsgc_pkg::SUM_W'(ram_rdata[2*nsgc_pkg::BYTE_W-1:nsgc_pkg::BYTE_W])
			+ nsgc_pkg::SUM_W'(nsgc_pkg::W_B2)
				* nsgc_pkg::SUM_W'(ram_rdata[3*nsgc_pkg::BYTE_W-1:2*nsgc_pkg::BYTE_W]);
	end

	assign product = nsgc_pkg::PROD_W'(sum_s12) * nsgc_pkg::PROD_W'(nsgc_pkg::RECIP_M);

	always_comb begin
		push_data.oor = meta_s12.oor;
		if (meta_s12.oor) begin
			push_data.gray = '0;
		end else if (rgb_mode_q) begin
			push_data.gray = product[nsgc_pkg::RECIP_SHIFT +: nsgc_pkg::BYTE_W];
		end else begin
			push_data.gray = luma_s12;
		end
	end

	// ---------------- result queue ----------------
	nsgc_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (meta_s12.valid),
		.push_data (push_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign gray         = out_data.gray;
	assign out_of_range = out_data.oor;

endmodule
`default_nettype wire

/* design/nsgc_check.sv */
`default_nettype none
module nsgc_check (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic [nsgc_pkg::BYTE_W-1:0]         gray,
	input wire logic                                out_of_range
);

	// queue is empty while reset is held
	a_no_result_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// a flagged item always carries zero gray
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> gray == '0)
		else $error("out-of-range item with nonzero gray");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled item withdrawn");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(gray) && $stable(out_of_range))
		else $error("stalled item changed");

endmodule

bind nearest_scale_gray_convert_core nsgc_check u_check (.*);
`default_nettype wire
